// ===== src/plh_pkg.sv =====
// ----------------------------------------------------------------------------
// plh_pkg
// Shared types, constants and the mix step of the path name lookup2 hash.
// ----------------------------------------------------------------------------
package plh_pkg;

	localparam int MAX_NAME_LEN = 255;
	localparam int LEN_W        = $clog2(MAX_NAME_LEN + 1);

	localparam logic [31:0] GOLDEN = 32'h9e3779b9;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE_ENABLE = 2'd1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] MIX_LAST = 4'd8;

	// one unit of work for the mixing engine
	typedef struct packed {
		logic [31:0]      wa;
		logic [31:0]      wb;
		logic [31:0]      wc;
		logic [31:0]      seed;
		logic [LEN_W-1:0] len;
		logic             first;  // first job of a name: start from golden/seed
		logic             blk;    // full 12-byte block
		logic             fin;    // name ends with this job
	} job_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} abc_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MIX,
		BK_TAIL,
		BK_OUT
	} bk_state_t;

	// one line of the lookup2 mix; nine lines make a full mix
	function automatic abc_t mix_step(input abc_t v, input logic [STEP_W-1:0] step);
		abc_t r;
		r = v;
		case (step)
			4'd0: r.a = (v.a - v.b - v.c) ^ (v.c >> 13);
			4'd1: r.b = (v.b - v.c - v.a) ^ (v.a << 8);
			4'd2: r.c = (v.c - v.a - v.b) ^ (v.b >> 13);
			4'd3: r.a = (v.a - v.b - v.c) ^ (v.c >> 12);
			4'd4: r.b = (v.b - v.c - v.a) ^ (v.a << 16);
			4'd5: r.c = (v.c - v.a - v.b) ^ (v.b >> 5);
			4'd6: r.a = (v.a - v.b - v.c) ^ (v.c >> 3);
			4'd7: r.b = (v.b - v.c - v.a) ^ (v.a << 10);
			4'd8: r.c = (v.c - v.a - v.b) ^ (v.b >> 15);
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

// ===== src/path_name_lookup2_hash.sv =====
// ----------------------------------------------------------------------------
// path_name_lookup2_hash
// Lookup2 hash of normalized file path names, one byte per transfer.
// ----------------------------------------------------------------------------
// Throughput: one name byte per cycle while the job queue is not full; the
//   mix engine finishes a 12-byte block sooner than its bytes arrive, so long
//   names stream without stalls unless the output is held off.
// Result: the last job is popped and mixed, then file_id is registered; a
//   closing block on the last byte adds a tail step and a second full mix.
// Short names are bounded by the mix engine, behind a 4-deep job queue.
// Reset: asynchronous, resets byte packer, config registers, queue and
//   output valid; accumulators reload on the first job of each name.
// ----------------------------------------------------------------------------
module path_name_lookup2_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // name_byte
	input  logic                          s_tuser,   // has_byte
	input  logic                          s_tlast,   // is_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // file_id
	input  logic                          cfg_we,
	input  logic [plh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import plh_pkg::*;

	logic q_push;
	logic q_pop;
	logic q_empty;
	logic q_full;
	job_t push_job;
	job_t head;

	plh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (q_push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	plh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	plh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job popped from empty queue");

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty at once");

	a_result_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(q_pop))
		else $error("result issued right after a pop");

endmodule

// ===== src/plh_front.sv =====
// ----------------------------------------------------------------------------
// plh_front
// Takes name bytes, normalizes them when enabled, packs 12-byte blocks and issues jobs.
// ----------------------------------------------------------------------------
module plh_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // name_byte
	input  logic                            s_tuser,   // has_byte
	input  logic                            s_tlast,   // is_last
	input  logic                            cfg_we,
	input  logic [plh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	output logic                            push,
	output plh_pkg::job_t                   push_job,
	input  logic                            q_full
);
	import plh_pkg::*;

	logic [31:0]      init_q;
	logic             norm_q;
	logic [31:0]      seed_q;
	logic [LEN_W-1:0] len_q;
	logic [3:0]       fill_q;
	logic [95:0]      pack_q;
	logic             first_q;

	logic             accept;
	logic             active;
	logic [7:0]       nb;
	logic [95:0]      pack_next;
	logic [LEN_W-1:0] len_next;
	logic             blk;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign active   = s_tuser && (len_q < LEN_W'(MAX_NAME_LEN));
	assign blk      = active && (fill_q == 4'd11);
	assign len_next = len_q + LEN_W'(active);
	assign push     = accept && (blk || s_tlast);

	always_comb begin
		nb = s_tdata;
		if (norm_q) begin
			if (s_tdata >= 8'h41 && s_tdata <= 8'h5a)
				nb = s_tdata + 8'h20;
			else if (s_tdata == 8'h2f)
				nb = 8'h5c;
		end
	end

	always_comb begin
		pack_next = pack_q;
		if (active)
			pack_next[{fill_q, 3'b000} +: 8] = nb;
	end

	always_comb begin
		push_job.wa    = pack_next[31:0];
		push_job.wb    = pack_next[63:32];
		// tail bytes 8..10 land one byte up; the length fills the low byte slot
		push_job.wc    = blk ? pack_next[95:64]
		                     : {pack_next[87:64], 8'h00} + 32'(len_next);
		push_job.seed  = (len_q == '0) ? init_q : seed_q;
		push_job.len   = len_next;
		push_job.first = first_q;
		push_job.blk   = blk;
		push_job.fin   = s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			norm_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INITIAL_VALUE:    init_q <= cfg_data;
				CFG_NORMALIZE_ENABLE: norm_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			len_q   <= '0;
			fill_q  <= '0;
			pack_q  <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (len_q == '0)
				seed_q <= init_q;
			if (s_tlast) begin
				len_q   <= '0;
				fill_q  <= '0;
				pack_q  <= '0;
				first_q <= 1'b1;
			end else if (blk) begin
				len_q   <= len_next;
				fill_q  <= '0;
				pack_q  <= '0;
				first_q <= 1'b0;
			end else if (active) begin
				len_q  <= len_next;
				fill_q <= fill_q + 4'd1;
				pack_q <= pack_next;
			end
		end
	end

endmodule

// ===== src/plh_queue.sv =====
// ----------------------------------------------------------------------------
// plh_queue
// Small job FIFO between the byte front end and the mixing engine.
// ----------------------------------------------------------------------------
module plh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  plh_pkg::job_t push_job,
	input  logic          pop,
	output plh_pkg::job_t head,
	output logic          empty,
	output logic          full
);
	import plh_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== src/plh_back.sv =====
// ----------------------------------------------------------------------------
// plh_back
// Mixing engine: adds job words into a/b/c, runs the mix one line per cycle
// and hands out c at the end of a name.
// ----------------------------------------------------------------------------
module plh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  plh_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata   // file_id
);
	import plh_pkg::*;

	bk_state_t         state_q, state_next;
	abc_t              acc_q;
	abc_t              base;
	job_t              job_q;
	logic [STEP_W-1:0] step_q;
	logic              tail_q;
	logic              load_out;
	logic              out_valid_q;
	logic [31:0]       out_data_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE: if (!empty) state_next = BK_MIX;
			BK_MIX: begin
				if (step_q == MIX_LAST) begin
					if (job_q.blk && job_q.fin && !tail_q)
						state_next = BK_TAIL;
					else if (job_q.fin)
						state_next = BK_OUT;
					else
						state_next = BK_IDLE;
				end
			end
			BK_TAIL: state_next = BK_MIX;
			BK_OUT:  if (!out_valid_q || m_tready) state_next = BK_IDLE;
			default: state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == BK_IDLE) && !empty;
		load_out = (state_q == BK_OUT) && (!out_valid_q || m_tready);
	end

	always_comb begin
		if (head.first) begin
			base.a = GOLDEN;
			base.b = GOLDEN;
			base.c = head.seed;
		end else begin
			base = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			tail_q      <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				BK_IDLE: begin
					step_q <= '0;
					tail_q <= 1'b0;
				end
				BK_MIX:  step_q <= (step_q == MIX_LAST) ? '0 : step_q + 1'b1;
				BK_TAIL: tail_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q   <= head;
			acc_q.a <= base.a + head.wa;
			acc_q.b <= base.b + head.wb;
			acc_q.c <= base.c + head.wc;
		end else if (state_q == BK_MIX) begin
			acc_q <= mix_step(acc_q, step_q);
		end else if (state_q == BK_TAIL) begin
			// last byte closed a block: the length goes into an empty tail
			acc_q.c <= acc_q.c + 32'(job_q.len);
		end
		if (load_out)
			out_data_q <= acc_q.c;
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for path_name_lookup2_hash. Path names go in one byte
// per transfer, with random bursts and gaps. A local lookup2 model predicts
// each file_id. Every result is compared in order. The receiver stalls on
// its own pattern, and once holds off long enough to back up the input side.
// ----------------------------------------------------------------------------
module testbench;
	import plh_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX_HI = 2'd3;

	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_Z   = 8'h5a;
	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_CYCLES     = 400;
	localparam int HOLD_AFTER_IDS  = 20;

	typedef struct packed {
		logic [7:0] nb;
		logic       has;
		logic       last;
	} path_item_t;

	localparam int N_DIRECTED = 25;
	localparam path_item_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{8'h00, 1'b0, 1'b1},  // empty name right after reset
		'{8'h41, 1'b1, 1'b0},  // 'A'
		'{8'h5a, 1'b1, 1'b0},  // 'Z'
		'{8'h40, 1'b1, 1'b0},  // just below 'A'
		'{8'h5b, 1'b1, 1'b0},  // just above 'Z'
		'{8'h2f, 1'b1, 1'b0},  // slash
		'{8'ha5, 1'b0, 1'b0},  // ignored transfer
		'{8'h5c, 1'b1, 1'b0},  // backslash
		'{8'h00, 1'b1, 1'b0},  // zero byte is hashed, does not end the name
		'{8'hff, 1'b1, 1'b0},
		'{8'h61, 1'b1, 1'b0},
		'{8'h7a, 1'b1, 1'b0},
		'{8'h2e, 1'b1, 1'b0},
		'{8'h01, 1'b1, 1'b1},  // 12th byte ends the name: full block on last
		'{8'h43, 1'b1, 1'b0},  // 11-byte name, leftover reaches c
		'{8'h2f, 1'b1, 1'b0},
		'{8'h77, 1'b1, 1'b0},
		'{8'h49, 1'b1, 1'b0},
		'{8'h4e, 1'b1, 1'b0},
		'{8'h44, 1'b1, 1'b0},
		'{8'h4f, 1'b1, 1'b0},
		'{8'h57, 1'b1, 1'b0},
		'{8'h53, 1'b1, 1'b0},
		'{8'h2f, 1'b1, 1'b0},
		'{8'h58, 1'b1, 1'b1}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = 8'h00;
	logic                 s_tuser   = 1'b0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [31:0]          m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;

	path_name_lookup2_hash uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---- lookup2 predictor --------------------------------------------------
	logic [31:0] seed_reg;
	logic        fold_en;
	logic [31:0] hash_a, hash_b, hash_c;
	logic [7:0]  blk_bytes [12];
	int unsigned blk_fill;
	int unsigned name_len;

	logic [31:0] pending_ids [$];

	function automatic void lookup2_mix(inout logic [31:0] a, inout logic [31:0] b,
			inout logic [31:0] c);
		a = (a - b - c) ^ (c >> 13);
		b = (b - c - a) ^ (a << 8);
		c = (c - a - b) ^ (b >> 13);
		a = (a - b - c) ^ (c >> 12);
		b = (b - c - a) ^ (a << 16);
		c = (c - a - b) ^ (b >> 5);
		a = (a - b - c) ^ (c >> 3);
		b = (b - c - a) ^ (a << 10);
		c = (c - a - b) ^ (b >> 15);
	endfunction

	function automatic logic [31:0] block_word(int base);
		return {blk_bytes[base+3], blk_bytes[base+2], blk_bytes[base+1], blk_bytes[base]};
	endfunction

	function automatic void restart_name();
		hash_a = GOLDEN;
		hash_b = GOLDEN;
		hash_c = seed_reg;
		foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
		blk_fill = 0;
		name_len = 0;
	endfunction

	function automatic bit hash_item(input path_item_t it, output logic [31:0] id);
		logic [7:0] nb;
		nb = it.nb;
		id = '0;
		if (it.has && name_len < MAX_NAME_LEN) begin
			if (fold_en) begin
				if (nb >= CH_UPPER_A && nb <= CH_UPPER_Z)
					nb = nb + CASE_OFFSET;
				else if (nb == CH_SLASH)
					nb = CH_BACKSLASH;
			end
			blk_bytes[blk_fill] = nb;
			blk_fill++;
			name_len++;
			if (blk_fill == 12) begin
				hash_a += block_word(0);
				hash_b += block_word(4);
				hash_c += block_word(8);
				lookup2_mix(hash_a, hash_b, hash_c);
				blk_fill = 0;
			end
		end
		if (!it.last)
			return 1'b0;
		hash_c += name_len;
		// leftover bytes; c's low byte is reserved for the length
		for (int unsigned i = 0; i < blk_fill && i < 11; i++) begin
			if (i < 4)
				hash_a += 32'(blk_bytes[i]) << (8 * i);
			else if (i < 8)
				hash_b += 32'(blk_bytes[i]) << (8 * (i - 4));
			else
				hash_c += 32'(blk_bytes[i]) << (8 * (i - 7));
		end
		lookup2_mix(hash_a, hash_b, hash_c);
		id = hash_c;
		restart_name();
		return 1'b1;
	endfunction

	// ---- result checker -----------------------------------------------------
	int          errors   = 0;
	int          ids_seen = 0;
	logic [31:0] id_want;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_ids.size() == 0) begin
				$display("%0t: unexpected file_id, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				id_want = pending_ids.pop_front();
				if (m_tdata !== id_want) begin
					$display("%0t: file_id mismatch, expected %h, actual %h",
						$time, id_want, m_tdata);
					errors++;
				end
			end
			ids_seen++;
		end
	end

	// ---- receiver: stall pattern plus one long hold-off ---------------------
	int rx_mode     = 0;
	int rx_mode_cnt = 0;
	int hold_cnt    = 0;
	bit hold_done   = 1'b0;

	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && ids_seen >= HOLD_AFTER_IDS) begin
			hold_done <= 1'b1;
			hold_cnt  <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			if (rx_mode_cnt == 0) begin
				rx_mode     <= $urandom_range(0, 3);
				rx_mode_cnt <= $urandom_range(20, 200);
			end else begin
				rx_mode_cnt <= rx_mode_cnt - 1;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 7) == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// ---- sender -------------------------------------------------------------
	int items_sent = 0;
	int burst_left = 0;
	bit no_gaps    = 1'b0;

	task automatic offer(input path_item_t it);
		logic [31:0] id;
		int          gap;
		s_tvalid <= 1'b1;
		s_tdata  <= it.nb;
		s_tuser  <= it.has;
		s_tlast  <= it.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (hash_item(it, id))
			pending_ids.push_back(id);
		if (it.has || it.last)
			items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = no_gaps ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
	endtask

	function automatic logic [7:0] path_char();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
			2: return $urandom_range(0, 1) ? CH_SLASH : CH_BACKSLASH;
			default: return 8'($urandom_range(8'h2d, 8'h7e));
		endcase
	endfunction

	// len bytes; terminated on the last byte or by a separate empty item,
	// or left open when partial is set
	task automatic send_name(input int len, input bit partial);
		bit sep_term;
		sep_term = (len == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				offer('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
			offer('{path_char(), 1'b1, !partial && !sep_term && (i == len - 1)});
		end
		if (!partial && sep_term)
			offer('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 59);
		if (r == 0)
			return $urandom_range(MAX_NAME_LEN + 1, 300);
		if (r <= 10)
			return 12 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
		return $urandom_range(0, 30);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_INITIAL_VALUE) begin
			seed_reg = data;
			// mid-name writes only apply from the next name
			if (name_len == 0)
				hash_c = data;
		end else if (idx == CFG_NORMALIZE_ENABLE) begin
			fold_en = data[0];
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_ids.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---- main sequence ------------------------------------------------------
	initial begin
		seed_reg = 32'h0;
		fold_en  = 1'b1;
		restart_name();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++)
			offer(DIRECTED_ROWS[r]);
		wait_idle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_INITIAL_VALUE, 32'hffff_ffff);
					write_reg(CFG_NORMALIZE_ENABLE, 32'h0);
				end
				1: begin
					write_reg(CFG_INITIAL_VALUE, 32'h0);
					write_reg(CFG_NORMALIZE_ENABLE, 32'h1);
				end
				2: begin
					write_reg(CFG_BAD_IDX_LO, $urandom());
					write_reg(CFG_BAD_IDX_HI, $urandom());
					write_reg(CFG_NORMALIZE_ENABLE, 32'hffff_fffe);
				end
				default: begin
					write_reg(CFG_NORMALIZE_ENABLE, $urandom());
					write_reg(CFG_INITIAL_VALUE, $urandom());
				end
			endcase
			no_gaps = (ph % 3 == 2);
			if (ph == 4)
				send_name(300, 1'b0);
			while (items_sent < N_DIRECTED + (ph + 1) * ITEMS_PER_PHASE)
				send_name(pick_len(), 1'b0);
			// leave a name open so the next phase's config writes land mid-name
			if (ph % 2 == 1 && ph < NUM_PHASES - 1)
				send_name($urandom_range(1, 14), 1'b1);
			wait_idle();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
